/* rtl/core/lpht_pkg.sv */
// Shared types, codes and constants for the linear probing hash table.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

	// Default sizing of the table
	localparam int SLOTS_DEF    = 16;
	localparam int KEY_BITS_DEF = 16;

	// Fixed field widths of the transaction payloads
	localparam int KEY_W       = 16;
	localparam int SLOT_W      = 4;
	localparam int STATUS_W    = 3;
	localparam int KEY_COUNT_W = 4;
	localparam int SLOT_VALS   = 1 << SLOT_W;

	typedef enum logic [STATUS_W-1:0] {
		STAT_FOUND     = 3'd0,
		STAT_INSERTED  = 3'd1,
		STAT_OVERFLOW  = 3'd2,
		STAT_DELETED   = 3'd3,
		STAT_DEL_EMPTY = 3'd4
	} status_t;

	typedef enum logic {
		OP_SEARCH_INSERT = 1'b0,
		OP_DELETE        = 1'b1
	} op_t;

	// Table write port source
	typedef enum logic [2:0] {
		WR_NONE   = 3'd0,
		WR_CLEAR  = 3'd1,
		WR_INSERT = 3'd2,
		WR_MOVE   = 3'd3,
		WR_GAP    = 3'd4
	} wr_sel_t;

	// Source of the reported slot
	typedef enum logic [1:0] {
		RS_PTR  = 2'd0,
		RS_SLOT = 2'd1,
		RS_ZERO = 2'd2
	} rslot_t;

	typedef struct packed {
		logic               operation;
		logic [KEY_W-1:0]   key;
		logic [SLOT_W-1:0]  home_slot;
		logic [SLOT_W-1:0]  slot;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [SLOT_W-1:0]      result_slot;
		logic [KEY_COUNT_W-1:0] key_count;
	} rsp_t;

	typedef struct packed {
		logic    ld;
		logic    ptr_adv;
		logic    j_ld;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    clr_adv;
		wr_sel_t wr;
		logic    res_ld;
		status_t res_status;
		rslot_t  res_slot;
		logic    rsp_ld;
	} ctrl_cmd_t;

	typedef struct packed {
		logic occ;
		logic key_hit;
		logic stays;
		logic at_gap;
		logic full;
		logic clr_last;
	} dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/lpht_dp.sv */
// Datapath: slot table memory, probe and gap pointers, key count, result registers.
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp #(
	parameter int SLOTS    = lpht_pkg::SLOTS_DEF,
	parameter int KEY_BITS = lpht_pkg::KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lpht_pkg::req_t      req,
	input  lpht_pkg::ctrl_cmd_t cmd,
	output lpht_pkg::dp_stat_t  stat,
	output lpht_pkg::rsp_t      rsp
);
	import lpht_pkg::*;

	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int ENT_W = 1 + SW + KW;
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

	// Entry layout: {occupied, home, key}
	logic [ENT_W-1:0] mem [SLOTS];
	logic [ENT_W-1:0] rd_q;
	logic [SW-1:0]    rd_addr;
	logic             wr_en;
	logic [SW-1:0]    wr_addr;
	logic [ENT_W-1:0] wr_data;

	logic [SW-1:0] mod_tbl [SLOT_VALS];
	logic [SW-1:0] start_slot;

	logic [KW-1:0]       key_q;
	logic [SW-1:0]       home_q;
	logic [SW-1:0]       slot_q;
	logic [SW-1:0]       ptr_q;
	logic [SW-1:0]       j_q;
	logic [SW-1:0]       ptr_below;
	logic [SW-1:0]       cnt_q;
	logic [SW-1:0]       clr_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	rsp_t                rsp_q;

	logic [SW-1:0] rd_home;
	logic          stays;

	// Slot fields reduced modulo the table size
	for (genvar g = 0; g < SLOT_VALS; g++) begin : g_mod
		assign mod_tbl[g] = SW'(g % SLOTS);
	end

	assign start_slot = req.operation ? mod_tbl[req.slot] : mod_tbl[req.home_slot];
	assign ptr_below  = (ptr_q == '0) ? LAST_SLOT : ptr_q - 1'b1;
	assign rd_addr    = cmd.ld ? start_slot : ptr_below;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = j_q;
		wr_data = '0;
		case (cmd.wr)
			WR_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			WR_INSERT: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q;
				wr_data = {1'b1, home_q, key_q};
			end
			WR_MOVE: begin
				wr_en   = 1'b1;
				wr_data = rd_q;
			end
			WR_GAP: begin
				wr_en   = 1'b1;
			end
			default: begin
				wr_en   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Entry at the probe slot stays put when its home lies cyclically in [ptr, gap)
	assign rd_home = rd_q[ENT_W-2 -: SW];
	always_comb begin
		if (ptr_q < j_q) begin
			stays = (rd_home >= ptr_q) && (rd_home < j_q);
		end else begin
			stays = (rd_home >= ptr_q) || (rd_home < j_q);
		end
	end

	assign stat.occ      = rd_q[ENT_W-1];
	assign stat.key_hit  = (rd_q[KW-1:0] == key_q);
	assign stat.stays    = stays;
	assign stat.at_gap   = (ptr_q == j_q);
	assign stat.full     = (cnt_q >= LAST_SLOT);
	assign stat.clr_last = (clr_q == LAST_SLOT);

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			key_q  <= req.key[KW-1:0];
			home_q <= mod_tbl[req.home_slot];
			slot_q <= mod_tbl[req.slot];
			ptr_q  <= start_slot;
		end else if (cmd.ptr_adv) begin
			ptr_q  <= ptr_below;
		end
		if (cmd.j_ld) begin
			j_q <= ptr_q;
		end
		if (cmd.res_ld) begin
			res_status_q <= cmd.res_status;
			case (cmd.res_slot)
				RS_PTR:  res_slot_q <= SLOT_W'(ptr_q);
				RS_SLOT: res_slot_q <= SLOT_W'(slot_q);
				default: res_slot_q <= '0;
			endcase
		end
		if (cmd.rsp_ld) begin
			rsp_q.status      <= res_status_q;
			rsp_q.result_slot <= res_slot_q;
			rsp_q.key_count   <= KEY_COUNT_W'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.clr_adv) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

/* rtl/core/lpht_ctrl.sv */
// Controller: sequences the clearing pass, probing, back-shift deletion and the response.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic                operation,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output lpht_pkg::ctrl_cmd_t cmd,
	input  lpht_pkg::dp_stat_t  stat
);
	import lpht_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_PROBE  = 6'b000100,
		ST_DCHECK = 6'b001000,
		ST_DSCAN  = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;

	always_comb begin
		state_d        = state_q;
		req_ready      = 1'b0;
		cmd            = '0;
		cmd.wr         = WR_NONE;
		cmd.res_status = STAT_FOUND;
		cmd.res_slot   = RS_PTR;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.wr      = WR_CLEAR;
				cmd.clr_adv = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.ld  = 1'b1;
					state_d = (operation == OP_DELETE) ? ST_DCHECK : ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (!stat.occ) begin
					cmd.res_ld = 1'b1;
					if (stat.full) begin
						cmd.res_status = STAT_OVERFLOW;
						cmd.res_slot   = RS_ZERO;
					end else begin
						cmd.wr         = WR_INSERT;
						cmd.cnt_inc    = 1'b1;
						cmd.res_status = STAT_INSERTED;
					end
					state_d = ST_RESULT;
				end else if (stat.key_hit) begin
					cmd.res_ld     = 1'b1;
					cmd.res_status = STAT_FOUND;
					state_d        = ST_RESULT;
				end else begin
					cmd.ptr_adv = 1'b1;
				end
			end
			ST_DCHECK: begin
				if (!stat.occ) begin
					cmd.res_ld     = 1'b1;
					cmd.res_status = STAT_DEL_EMPTY;
					cmd.res_slot   = RS_SLOT;
					state_d        = ST_RESULT;
				end else begin
					// open the gap at the named slot, scan from the one below
					cmd.cnt_dec = 1'b1;
					cmd.j_ld    = 1'b1;
					cmd.ptr_adv = 1'b1;
					state_d     = ST_DSCAN;
				end
			end
			ST_DSCAN: begin
				if (stat.at_gap || !stat.occ) begin
					// close out: empty whatever slot the gap ended in
					cmd.wr         = WR_GAP;
					cmd.res_ld     = 1'b1;
					cmd.res_status = STAT_DELETED;
					cmd.res_slot   = RS_SLOT;
					state_d        = ST_RESULT;
				end else begin
					if (!stat.stays) begin
						cmd.wr   = WR_MOVE;
						cmd.j_ld = 1'b1;
					end
					cmd.ptr_adv = 1'b1;
				end
			end
			ST_RESULT: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.rsp_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rsp_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

/* rtl/core/linear_probe_hash_table.sv */
// Top level of the open-addressed hash table with downward linear probing.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  request  | req_valid/req_ready  | req: operation, key, home_slot, slot
//  response | rsp_valid/rsp_ready  | rsp: status, result_slot, key_count
//
// A search-insert probes slots downward from its home slot; a delete scans the
// slots below the deleted one. The single read port of the slot table reads one
// slot a cycle. After reset a clearing pass empties the table; req_ready stays
// low until it is done. A response waiting on rsp_ready does not block acceptance
// of the next request; the block stalls only when its next response is ready.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table #(
	parameter int SLOTS    = lpht_pkg::SLOTS_DEF,
	parameter int KEY_BITS = lpht_pkg::KEY_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lpht_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lpht_pkg::rsp_t rsp
);
	import lpht_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.operation (req.operation),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	lpht_dp #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the linear probing hash table: shadow table, traffic and checks.
`timescale 1ns / 1ps

module tb;
	import lpht_pkg::*;

	// Shadow copy of the slot table; predicts the reply of every accepted request.
	class table_shadow;
		logic [KEY_W-1:0]  keys [SLOT_VALS];
		logic [SLOT_W-1:0] homes [SLOT_VALS];
		bit                occ [SLOT_VALS];
		int unsigned       held;
		rsp_t              awaited [$];
		int unsigned       errors;
		int unsigned       status_seen [5];
		int unsigned       longest_shift;
		int unsigned       full_events;

		function new();
			foreach (keys[i]) begin
				keys[i]  = '0;
				homes[i] = '0;
				occ[i]   = 1'b0;
			end
			held          = 0;
			errors        = 0;
			longest_shift = 0;
			full_events   = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		// An entry at i with home h keeps its place while h lies cyclically in [i, gap).
		function bit holds_position(logic [SLOT_W-1:0] i, logic [SLOT_W-1:0] gap,
				logic [SLOT_W-1:0] h);
			if (i < gap)
				return h >= i && h < gap;
			return h >= i || h < gap;
		endfunction

		function void vacate(logic [SLOT_W-1:0] s);
			occ[s]   = 1'b0;
			keys[s]  = '0;
			homes[s] = '0;
		endfunction

		function rsp_t probe_insert(logic [KEY_W-1:0] key, logic [SLOT_W-1:0] home);
			rsp_t              r;
			logic [SLOT_W-1:0] i;
			int                n;
			r.status      = STAT_OVERFLOW;
			r.result_slot = '0;
			r.key_count   = '0;
			i = home;
			for (n = 0; n < SLOT_VALS; n++) begin
				if (!occ[i])
					break;
				if (keys[i] == key) begin
					r.status      = STAT_FOUND;
					r.result_slot = i;
					return r;
				end
				i = i - 1'b1;
			end
			if (n < SLOT_VALS && held < SLOT_VALS - 1) begin
				occ[i]   = 1'b1;
				keys[i]  = key;
				homes[i] = home;
				held++;
				if (held == SLOT_VALS - 1)
					full_events++;
				r.status      = STAT_INSERTED;
				r.result_slot = i;
			end
			return r;
		endfunction

		// Empty the slot, then pull later cluster members back into the gap.
		function rsp_t shift_delete(logic [SLOT_W-1:0] victim);
			rsp_t              r;
			logic [SLOT_W-1:0] gap;
			logic [SLOT_W-1:0] i;
			bit                moved;
			int                moves;
			int                n;
			r.result_slot = victim;
			r.key_count   = '0;
			if (!occ[victim]) begin
				r.status = STAT_DEL_EMPTY;
				return r;
			end
			gap = victim;
			vacate(gap);
			held--;
			for (moves = 0; moves < SLOT_VALS; moves++) begin
				i     = gap;
				moved = 1'b0;
				for (n = 0; n < SLOT_VALS; n++) begin
					i = i - 1'b1;
					if (!occ[i] || i == gap)
						break;
					if (!holds_position(i, gap, homes[i])) begin
						moved = 1'b1;
						break;
					end
				end
				if (!moved)
					break;
				occ[gap]   = 1'b1;
				keys[gap]  = keys[i];
				homes[gap] = homes[i];
				vacate(i);
				gap = i;
			end
			if (moves > longest_shift)
				longest_shift = moves;
			r.status = STAT_DELETED;
			return r;
		endfunction

		function void note_request(req_t item);
			rsp_t r;
			if (item.operation == OP_DELETE)
				r = shift_delete(item.slot);
			else
				r = probe_insert(item.key, item.home_slot);
			r.key_count = held[KEY_COUNT_W-1:0];
			status_seen[r.status]++;
			awaited.push_back(r);
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 40)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_reply(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("reply with nothing outstanding, status %0d slot %0d",
					got.status, got.result_slot));
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.result_slot !== want.result_slot)
				report_mismatch($sformatf("result_slot %0d, want %0d",
					got.result_slot, want.result_slot));
			if (got.key_count !== want.key_count)
				report_mismatch($sformatf("key_count %0d, want %0d",
					got.key_count, want.key_count));
		endtask
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	table_shadow sb;
	bit          sender_eager = 1'b0;

	always #2 clk = ~clk;

	linear_probe_hash_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	task automatic send_request(input req_t item);
		int unsigned pause;
		bit          ready_seen;
		if ($urandom_range(0, 39) == 0)
			sender_eager = !sender_eager;
		pause = sender_eager ? 0 : $urandom_range(0, 12);
		if (pause != 0) begin
			req_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		// sample ready mid-cycle so the coming edge decides the handshake
		do begin
			@(negedge clk);
			ready_seen = req_ready;
			@(posedge clk);
		end while (!ready_seen);
		sb.note_request(item);
	endtask

	task automatic issue(input op_t op, input logic [KEY_W-1:0] key,
			input logic [SLOT_W-1:0] home, input logic [SLOT_W-1:0] victim);
		req_t item;
		item.operation = op;
		item.key       = key;
		item.home_slot = home;
		item.slot      = victim;
		send_request(item);
	endtask

	task automatic directed_phase();
		issue(OP_SEARCH_INSERT, 16'hFFFF, 4'd15, 4'd15);
		issue(OP_SEARCH_INSERT, 16'h0000, 4'd0, 4'd0);
		// collide at slot 0, wrap past 15 down to 14
		issue(OP_SEARCH_INSERT, 16'h1234, 4'd0, 4'd7);
		issue(OP_SEARCH_INSERT, 16'h1234, 4'd0, 4'd9);
		// the wrapped entry must move back into slot 0
		issue(OP_DELETE, 16'hFFFF, 4'd15, 4'd0);
		issue(OP_SEARCH_INSERT, 16'h1234, 4'd0, 4'd15);
		issue(OP_DELETE, 16'h0000, 4'd0, 4'd5);
		issue(OP_SEARCH_INSERT, 16'h0000, 4'd3, 4'd0);
		for (int k = 0; k < 12; k++)
			issue(OP_SEARCH_INSERT, 16'h8000 | KEY_W'(k), SLOT_W'(k), SLOT_W'(15 - k));
		// table now holds SLOTS-1 keys
		issue(OP_SEARCH_INSERT, 16'hA5A5, 4'd7, 4'd2);
		issue(OP_SEARCH_INSERT, 16'hFFFF, 4'd15, 4'd0);
		issue(OP_DELETE, 16'h5A5A, 4'd9, 4'd15);
		issue(OP_DELETE, 16'h0000, 4'd0, 4'd8);
	endtask

	task automatic random_phase(input int unsigned count);
		req_t              item;
		logic [KEY_W-1:0]  key_pool [24];
		logic [SLOT_W-1:0] live [$];
		logic [SLOT_W-1:0] cluster_base;
		bit                filling;
		int unsigned       mark;
		int unsigned       full_stay;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int k = 2; k < 24; k++)
			key_pool[k] = KEY_W'($urandom);
		cluster_base = SLOT_W'($urandom);
		filling      = 1'b0;
		mark         = 3;
		full_stay    = 0;
		for (int unsigned n = 0; n < count; n++) begin
			// alternate fill and drain phases so the table sweeps its whole load range
			if (filling && sb.held >= mark) begin
				if (full_stay != 0) begin
					full_stay--;
				end else begin
					filling      = 1'b0;
					mark         = $urandom_range(0, 5);
					cluster_base = SLOT_W'($urandom);
				end
			end else if (!filling && sb.held <= mark) begin
				filling   = 1'b1;
				mark      = $urandom_range(6, SLOT_VALS - 1);
				full_stay = (mark == SLOT_VALS - 1) ? $urandom_range(2, 8) : 0;
			end
			item.operation = ($urandom_range(0, 99) < (filling ? 85 : 30)) ?
				OP_SEARCH_INSERT : OP_DELETE;
			item.key = ($urandom_range(0, 99) < 65) ? key_pool[$urandom_range(0, 23)] :
				KEY_W'($urandom);
			item.home_slot = ($urandom_range(0, 99) < 60) ?
				SLOT_W'(cluster_base + SLOT_W'($urandom_range(0, 3))) : SLOT_W'($urandom);
			live.delete();
			foreach (sb.occ[s])
				if (sb.occ[s])
					live.push_back(SLOT_W'(s));
			if (live.size() != 0 && $urandom_range(0, 99) < 80)
				item.slot = live[$urandom_range(0, live.size() - 1)];
			else
				item.slot = SLOT_W'($urandom);
			send_request(item);
		end
	endtask

	initial begin : reply_sink
		int unsigned pause;
		int unsigned taken;
		bit          eager;
		bit          valid_seen;
		rsp_t        got;
		taken = 0;
		eager = 1'b0;
		forever begin
			if ($urandom_range(0, 39) == 0)
				eager = !eager;
			pause = eager ? 0 : $urandom_range(0, 12);
			// hold off long enough for the block to back up into its request side
			if (taken == 500)
				pause = 400;
			if (pause != 0) begin
				rsp_ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			// sample valid and payload mid-cycle, ahead of the deciding edge
			do begin
				@(negedge clk);
				valid_seen = rsp_valid;
				got        = rsp;
				@(posedge clk);
			end while (!valid_seen);
			sb.check_reply(got);
			taken++;
		end
	end

	initial begin : watchdog
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : main_flow
		int unsigned total;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		directed_phase();
		random_phase(1600);
		req_valid <= 1'b0;
		for (int w = 0; w < 4000 && sb.awaited.size() != 0; w++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.awaited.size() != 0)
			sb.report_mismatch($sformatf("%0d replies never arrived", sb.awaited.size()));
		total = 0;
		foreach (sb.status_seen[i])
			total += sb.status_seen[i];
		$display("Ran %0d requests: %0d found, %0d inserted, %0d overflow, %0d deleted, %0d empty deletes.",
			total, sb.status_seen[STAT_FOUND], sb.status_seen[STAT_INSERTED],
			sb.status_seen[STAT_OVERFLOW], sb.status_seen[STAT_DELETED],
			sb.status_seen[STAT_DEL_EMPTY]);
		$display("Table filled to capacity %0d times; longest back-shift chain %0d moves.",
			sb.full_events, sb.longest_shift);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/lpht_pkg.sv
rtl/core/lpht_dp.sv
rtl/core/lpht_ctrl.sv
rtl/core/linear_probe_hash_table.sv
verif/tb.sv
